// ===== rtl/bsr_pkg.sv =====
// Package for the bisection square root block.
// Holds shared widths, the controller state type and the command and status structs.
// No dependencies.
package bsr_pkg;

  // Field and datapath widths fixed by the interface.
  localparam int unsigned ValueW = 32;
  localparam int unsigned RootW  = 25;
  localparam int unsigned StepsW = 7;
  localparam int unsigned BoundW = 32;
  localparam int unsigned SqW    = 64;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_UP,
    ST_CHK_UP,
    ST_SQ_MID,
    ST_CHK_MID
  } bsr_state_e;

  // Source of the returned root.
  typedef enum logic [1:0] {
    ROOT_ZERO,
    ROOT_UPPER,
    ROOT_MID
  } bsr_root_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic          load;
    logic          mul_en;
    logic          mul_mid;
    logic          init_mid;
    logic          step;
    logic          out_load;
    bsr_root_sel_e root_sel;
    logic          conv;
  } bsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic value_zero;
    logic up_exact;
    logic within_tol;
    logic step_cap;
    logic res_end;
  } bsr_sts_t;

endpackage

// ===== rtl/bisection_square_root.sv =====
// An exact bound or a zero value is returned after the upper bound is squared and checked,
// with no halving; otherwise each halving step squares the midpoint on the shared 32x32
// squarer, then compares and updates the bracket, for at most MAX_STEPS steps.
// A new item is accepted only in idle, after the previous result has been registered.
// Reset: asynchronous, active low; the block returns to idle, no result is pending,
// and the tolerance register reads one LSB.
module bisection_square_root #(
  parameter int unsigned MAX_STEPS = 48,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bsr_pkg::ValueW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bsr_pkg::ValueW-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bsr_pkg::RootW-1:0]  root_o,
  output logic [bsr_pkg::StepsW-1:0] steps_o,
  output logic                       converged_o
);

  bsr_pkg::bsr_cmd_t cmd;
  bsr_pkg::bsr_sts_t sts;

  // Controller.
  bsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  bsr_dp #(
    .MAX_STEPS (MAX_STEPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .root_o      (root_o),
    .steps_o     (steps_o),
    .converged_o (converged_o)
  );

endmodule

// ===== rtl/bsr_ctrl.sv =====
// Controller state machine for the bisection square root block.
// Sequences load, squaring, checking and result hand-off; depends on bsr_pkg.
module bsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  bsr_pkg::bsr_sts_t sts_i,
  output bsr_pkg::bsr_cmd_t cmd_o
);

  bsr_pkg::bsr_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // State register and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.root_sel = bsr_pkg::ROOT_MID;
    in_stall_o   = 1'b1;
    case (state_q)
      bsr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bsr_pkg::ST_SQ_UP;
        end
      end
      bsr_pkg::ST_SQ_UP: begin
        cmd_o.mul_en = 1'b1;
        state_d      = bsr_pkg::ST_CHK_UP;
      end
      bsr_pkg::ST_CHK_UP: begin
        if (sts_i.value_zero || sts_i.up_exact) begin
          // A zero value or an exact bound is returned without any halving.
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.conv     = 1'b1;
            if (sts_i.value_zero) begin
              cmd_o.root_sel = bsr_pkg::ROOT_ZERO;
            end else begin
              cmd_o.root_sel = bsr_pkg::ROOT_UPPER;
            end
            state_d        = bsr_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.init_mid = 1'b1;
          state_d        = bsr_pkg::ST_SQ_MID;
        end
      end
      bsr_pkg::ST_SQ_MID: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_mid = 1'b1;
        state_d       = bsr_pkg::ST_CHK_MID;
      end
      bsr_pkg::ST_CHK_MID: begin
        if (sts_i.within_tol || sts_i.step_cap || sts_i.res_end) begin
          // Search ends; converged only when the error is within tolerance.
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.conv     = sts_i.within_tol;
            cmd_o.root_sel = bsr_pkg::ROOT_MID;
            state_d        = bsr_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d    = bsr_pkg::ST_SQ_MID;
        end
      end
      default: begin
        state_d = bsr_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: set on a new result, held while stalled.
  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/bsr_dp.sv =====
// Datapath for the bisection square root block: bounds, squarer, compares and result register.
// Holds the tolerance register; depends on bsr_pkg.
module bsr_dp #(
  parameter int unsigned MAX_STEPS = 48,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bsr_pkg::ValueW-1:0]        cfg_wdata_i,
  input  logic [bsr_pkg::ValueW-1:0]        value_i,
  input  bsr_pkg::bsr_cmd_t                 cmd_i,
  output bsr_pkg::bsr_sts_t                 sts_o,
  output logic [bsr_pkg::RootW-1:0]         root_o,
  output logic [bsr_pkg::StepsW-1:0]        steps_o,
  output logic                              converged_o
);

  localparam logic [bsr_pkg::BoundW-1:0] One = bsr_pkg::BoundW'(1) << FRAC_BITS;
  localparam logic [bsr_pkg::StepsW-1:0] StepCap = bsr_pkg::StepsW'(MAX_STEPS);

  logic [bsr_pkg::ValueW-1:0] tol_q;
  logic                       value_zero_q;
  logic [bsr_pkg::SqW-1:0]    vw_q, hi_q, lo_q, sq_q;
  logic [bsr_pkg::BoundW-1:0] lower_q, upper_q, mid_q;
  logic [bsr_pkg::StepsW-1:0] steps_q;
  logic [bsr_pkg::RootW-1:0]  root_q;
  logic [bsr_pkg::StepsW-1:0] steps_out_q;
  logic                       conv_q;

  logic [bsr_pkg::SqW-1:0]    vw_d, tw_d, sq_d;
  logic [bsr_pkg::BoundW-1:0] mul_op, sum_a, sum_b, upper_init;
  logic [bsr_pkg::BoundW:0]   sum;
  logic                       sq_low;

  // Tolerance register; the user must write it only while idle, the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= bsr_pkg::ValueW'(1);
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Value and tolerance at double precision; the error window is set up once per item.
  assign vw_d       = bsr_pkg::SqW'(value_i) << FRAC_BITS;
  assign tw_d       = bsr_pkg::SqW'(tol_q) << FRAC_BITS;
  assign upper_init = (value_i > One) ? value_i : One;

  // Squarer operand selection and product.
  assign mul_op = cmd_i.mul_mid ? mid_q : upper_q;
  assign sq_d   = mul_op * mul_op;

  // Midpoint adder: initial bracket or the half that keeps the root.
  assign sq_low = sq_q < vw_q;
  always_comb begin
    if (cmd_i.init_mid) begin
      sum_a = lower_q;
      sum_b = upper_q;
    end else if (sq_low) begin
      sum_a = mid_q;
      sum_b = upper_q;
    end else begin
      sum_a = lower_q;
      sum_b = mid_q;
    end
  end
  assign sum = {1'b0, sum_a} + {1'b0, sum_b};

  // Search registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vw_q         <= vw_d;
      hi_q         <= vw_d + tw_d;
      lo_q         <= (vw_d > tw_d) ? (vw_d - tw_d) : '0;
      value_zero_q <= (value_i == '0);
      lower_q      <= '0;
      upper_q      <= upper_init;
      steps_q      <= '0;
    end else if (cmd_i.step) begin
      if (sq_low) begin
        lower_q <= mid_q;
      end else begin
        upper_q <= mid_q;
      end
      steps_q <= steps_q + bsr_pkg::StepsW'(1);
    end
    if (cmd_i.init_mid || cmd_i.step) begin
      mid_q <= sum[bsr_pkg::BoundW:1];
    end
    if (cmd_i.mul_en) begin
      sq_q <= sq_d;
    end
  end

  // Status toward the controller.
  assign sts_o.value_zero = value_zero_q;
  assign sts_o.up_exact   = (sq_q == vw_q);
  assign sts_o.within_tol = (sq_q <= hi_q) && (sq_q >= lo_q);
  assign sts_o.step_cap   = (steps_q >= StepCap);
  assign sts_o.res_end    = ((upper_q - lower_q) <= bsr_pkg::BoundW'(1));

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.root_sel)
        bsr_pkg::ROOT_ZERO:  root_q <= '0;
        bsr_pkg::ROOT_UPPER: root_q <= upper_q[bsr_pkg::RootW-1:0];
        bsr_pkg::ROOT_MID:   root_q <= mid_q[bsr_pkg::RootW-1:0];
        default:             root_q <= mid_q[bsr_pkg::RootW-1:0];
      endcase
      steps_out_q <= steps_q;
      conv_q      <= cmd_i.conv;
    end
  end

  assign root_o      = root_q;
  assign steps_o     = steps_out_q;
  assign converged_o = conv_q;

endmodule

// ===== rtl/bsr_checker.sv =====
// Port-level checker for the bisection square root block, bound to the top level.
// Depends on bsr_pkg for field widths.
module bsr_checker #(
  parameter int unsigned MAX_STEPS = 48
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [bsr_pkg::RootW-1:0]  root_o,
  input logic [bsr_pkg::StepsW-1:0] steps_o,
  input logic                       converged_o
);

  // A stalled result stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(root_o) && $stable(steps_o) && $stable(converged_o))
    else $error("result payload changed while stalled");

  // After a transaction on the input the block is busy with that item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted while searching");

  // A search that ends by cap or resolution has taken at least one step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !converged_o |-> steps_o != '0)
    else $error("unconverged result with no steps");

  // The step count never exceeds the cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> steps_o <= bsr_pkg::StepsW'(MAX_STEPS))
    else $error("step count above cap");

endmodule

bind bisection_square_root bsr_checker #(
  .MAX_STEPS (MAX_STEPS)
) u_bsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .root_o      (root_o),
  .steps_o     (steps_o),
  .converged_o (converged_o)
);

// ===== dv/bisection_square_root_tb.sv =====
// Self-checking testbench for the bisection square root block.
// Depends on bsr_pkg and bisection_square_root; a built-in predictor checks every result.
`timescale 1ns / 100ps

module bisection_square_root_tb;

  localparam int unsigned SqrtMaxSteps = 48;
  localparam int unsigned SqrtFrac     = 16;
  localparam logic [31:0] TolMax       = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [bsr_pkg::ValueW-1:0] value;
    logic [bsr_pkg::RootW-1:0]  root;
    logic [bsr_pkg::StepsW-1:0] steps;
    logic                       converged;
  } sqrt_result_t;

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [bsr_pkg::ValueW-1:0] cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [bsr_pkg::ValueW-1:0] value_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [bsr_pkg::RootW-1:0]  root_o;
  logic [bsr_pkg::StepsW-1:0] steps_o;
  logic                       converged_o;

  logic [31:0]                value_queue[$];
  sqrt_result_t               expected_roots[$];
  logic [31:0]                tol_model = 32'd1;
  bit                         no_idle = 1'b0;
  int unsigned                queued_cnt = 0;
  int unsigned                results_seen = 0;
  int unsigned                converged_cnt = 0;
  int unsigned                tol_settings = 1;
  int unsigned                mismatch_count = 0;

  bisection_square_root #(
    .MAX_STEPS(SqrtMaxSteps),
    .FRAC_BITS(SqrtFrac)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .root_o     (root_o),
    .steps_o    (steps_o),
    .converged_o(converged_o)
  );

  // Bisection search at double precision, the same way the block brackets the root.
  function automatic sqrt_result_t predict_sqrt(logic [31:0] v, logic [31:0] tol);
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  mid;
    logic [63:0]  target;
    logic [63:0]  allowed;
    logic [63:0]  sq;
    logic [63:0]  err;
    logic [63:0]  unity;
    int unsigned  n;
    bit           done;
    sqrt_result_t r;
    unity   = 64'd1 << SqrtFrac;
    target  = 64'(v) << SqrtFrac;
    allowed = 64'(tol) << SqrtFrac;
    lo      = '0;
    hi      = (64'(v) > unity) ? 64'(v) : unity;
    mid     = (lo + hi) >> 1;
    n       = 0;
    r.value = v;
    if (target == 64'd0) begin
      r.root      = '0;
      r.converged = 1'b1;
    end else if (hi * hi == target) begin
      r.root      = hi[bsr_pkg::RootW-1:0];
      r.converged = 1'b1;
    end else begin
      r.converged = 1'b0;
      done        = 1'b0;
      while (!done) begin
        sq  = mid * mid;
        err = (sq >= target) ? sq - target : target - sq;
        if (err <= allowed) begin
          r.converged = 1'b1;
          done        = 1'b1;
        end else if (n >= SqrtMaxSteps || hi - lo <= 64'd1) begin
          done = 1'b1;
        end else begin
          if (sq < target) lo = mid;
          else hi = mid;
          mid = (lo + hi) >> 1;
          n++;
        end
      end
      r.root = mid[bsr_pkg::RootW-1:0];
    end
    r.steps = n[bsr_pkg::StepsW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] v,
                                 input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH at %0t: %s for value 0x%08h: got 0x%0h, expected 0x%0h",
             $time, what, v, got, want);
    mismatch_count++;
  endtask

  // Operands favor bit patterns, perfect squares and values around 1.0.
  function automatic logic [31:0] random_value();
    logic [31:0] m;
    case ($urandom_range(0, 5))
      0: random_value = $urandom >> $urandom_range(0, 31);
      1: begin
        m = $urandom_range(0, 65535);
        random_value = m * m;
      end
      2: random_value = 32'h0001_0000 + $urandom_range(0, 64) - 32'd32;
      3: random_value = $urandom_range(0, 32'h0000_FFFF);
      default: random_value = $urandom;
    endcase
  endfunction

  task automatic queue_value(input logic [31:0] v);
    value_queue.push_back(v);
    queued_cnt++;
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) queue_value(random_value());
  endtask

  // Every accepted transaction returns exactly one result, so the block is idle once
  // the result count catches up with the queued count.
  task automatic wait_drained();
    while (results_seen != queued_cnt) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [31:0] t);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= t;
    tol_model = t;
    tol_settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Input driver: presents queued values and predicts the result on acceptance.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_roots.push_back(predict_sqrt(value_i, tol_model));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (value_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 15)) begin
          in_valid_i <= 1'b1;
          value_i    <= value_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output back-pressure.
  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < 15);
  end

  // Result monitor: compares each transaction with the oldest prediction.
  always @(posedge clk_i) begin
    sqrt_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (converged_o) converged_cnt++;
      if (expected_roots.size() == 0) begin
        report_mismatch("unexpected result", '0, 32'(root_o), '0);
      end else begin
        want = expected_roots.pop_front();
        if (root_o !== want.root)
          report_mismatch("root", want.value, 32'(root_o), 32'(want.root));
        if (steps_o !== want.steps)
          report_mismatch("steps", want.value, 32'(steps_o), 32'(want.steps));
        if (converged_o !== want.converged)
          report_mismatch("converged", want.value, 32'(converged_o), 32'(want.converged));
      end
    end
  end

  // Stimulus phases, one per tolerance setting.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset tolerance of one LSB: exact bounds, extremes and boundary values.
    queue_value(32'h0000_0000);
    queue_value(32'h0001_0000);
    queue_value(32'h0000_0001);
    queue_value(32'h0000_FFFF);
    queue_value(32'h0001_0001);
    queue_value(32'h0002_0000);
    queue_value(32'h0004_0000);
    queue_value(32'h0009_0000);
    queue_value(32'h0000_4000);
    queue_value(32'hFFFF_FFFF);
    queue_value(32'h8000_0000);
    queue_value(32'h7FFF_FFFF);
    queue_value(32'hFFFE_0001);
    queue_value(32'h5555_5555);
    queue_value(32'hAAAA_AAAA);

    // Zero tolerance: the search ends by resolution unless the root is exact.
    write_tolerance(32'h0000_0000);
    queue_value(32'h0002_0000);
    queue_value(32'h0000_0001);
    queue_value(32'hFFFF_FFFF);
    queue_value(32'h0001_0000);
    queue_random(300);

    // Largest tolerance: the widest window, though large values still need halving steps before a midpoint qualifies.
    write_tolerance(TolMax);
    queue_value(32'h0001_0000);
    queue_value(32'hFFFF_FFFF);
    queue_value(32'h1234_5678);
    queue_value(32'h0000_0000);
    queue_random(150);

    // Small random tolerance with both sides running flat out.
    write_tolerance($urandom_range(1, 32'h0000_FFFF));
    no_idle = 1'b1;
    queue_random(450);
    wait_drained();
    no_idle = 1'b0;

    write_tolerance($urandom);
    queue_random(350);

    write_tolerance(32'h0000_0001);
    queue_random(400);

    wait_drained();
    repeat (2 * SqrtMaxSteps + 10) @(posedge clk_i);
    if (expected_roots.size() != 0)
      report_mismatch("results never arrived", '0, '0, 32'(expected_roots.size()));

    $display("Checked %0d square root transactions over %0d tolerance settings.",
             results_seen, tol_settings);
    $display("%0d of them converged within tolerance, %0d mismatches seen.",
             converged_cnt, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #8_000_000;
    $display("Timeout: %0d of %0d results received.", results_seen, queued_cnt);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bsr_pkg.sv
rtl/bsr_ctrl.sv
rtl/bsr_dp.sv
rtl/bisection_square_root.sv
rtl/bsr_checker.sv
dv/bisection_square_root_tb.sv
